// File: design/calendar_to_epoch_seconds_assert.svh
// Assertion macros shared by the date conversion modules.
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date conversion check failed");

// Next-cycle implication, checked outside reset.
`define CTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date conversion check failed");

`endif

// File: design/cte_pkg.sv
package cte_pkg;

  localparam int YEAR_W = 14;

  typedef logic [YEAR_W-1:0] year_t;

  localparam year_t START_YEAR_RST = 14'd1970;

  // floor(x / 100) for any 15-bit x, as a multiply by a rounded-up reciprocal.
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int RECIP_SH = 22;

  // Days in the months before the given month of a common year.
  localparam logic [8:0] DAYS_BEFORE [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  typedef struct packed {
    logic       valid;
    logic       early;
    year_t      year;
    year_t      start_year;
    logic [7:0] q_ceil_y;
    logic [7:0] q_ceil_s;
    logic [7:0] q_floor_y;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } s1_t;

  typedef struct packed {
    logic        valid;
    logic        early;
    year_t       dyear;
    logic [11:0] dleap;
    logic [8:0]  mdays;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } s2_t;

  typedef struct packed {
    logic        valid;
    logic        early;
    logic [31:0] days;
    logic [16:0] hms;
  } s3_t;

  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [30:0] p;
    p = {16'b0, x} * {15'b0, RECIP_100};
    return p[RECIP_SH+8:RECIP_SH];
  endfunction

endpackage

// File: design/calendar_to_epoch_seconds.sv
// Pipeline: a request accepted at one clock edge passes through four register
// stages, s1, s2, s3 and the output register, before it is on the result ports.
// Throughput: one request per cycle; busy stays low and the result strobe cannot stall.
// Reset: synchronous, active low; it clears the stage valid bits and loads
// start_year with 1970. Results in flight are dropped.
`include "calendar_to_epoch_seconds_assert.svh"

module calendar_to_epoch_seconds (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cte_pkg::year_t      in_year,
  input  logic [3:0]          in_month,
  input  logic [4:0]          in_day,
  input  logic [4:0]          in_hour,
  input  logic [5:0]          in_minute,
  input  logic [5:0]          in_second,
  output logic                out_valid,
  output logic [31:0]         out_epoch_seconds,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cte_pkg::year_t      cfg_start_year
);
  import cte_pkg::*;

  // The start year register. The user must rewrite it only while no request is
  // in flight, so every stage sees a stable value; the block does not enforce it.
  year_t start_year_r;
  s1_t   s1;
  s3_t   s3;

  // The pipeline has no back pressure: every stage advances each cycle, so
  // a request is taken whenever start is high.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_year_r <= START_YEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      start_year_r <= cfg_start_year;
    end
  end

  // Stage one: year comparison and the century quotients, each from a
  // reciprocal multiply.
  cte_leap_div u_leap_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start && !busy),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .in_hour    (in_hour),
    .in_minute  (in_minute),
    .in_second  (in_second),
    .start_year (start_year_r),
    .s1         (s1)
  );

  // Stages two and three: leap counts, month offset, then the day number and
  // the seconds within the day.
  cte_day_count u_day_count (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .s3    (s3)
  );

  // Stage four: days scaled to seconds and the registered result.
  cte_scale u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .s3                (s3),
    .out_valid         (out_valid),
    .out_epoch_seconds (out_epoch_seconds)
  );

  // Every accepted request produces its result strobe, and a strobe never
  // appears without an earlier request.
  `CTE_ASSERT_NXT(a_request_gives_result, clk, rst_n, start && !busy, ##3 out_valid)
  `CTE_ASSERT_IMP(a_result_has_request, clk, rst_n, out_valid, $past(start, 4))

endmodule

// File: design/cte_leap_div.sv
module cte_leap_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cte_pkg::year_t      in_year,
  input  logic [3:0]          in_month,
  input  logic [4:0]          in_day,
  input  logic [4:0]          in_hour,
  input  logic [5:0]          in_minute,
  input  logic [5:0]          in_second,
  input  cte_pkg::year_t      start_year,
  output cte_pkg::s1_t        s1
);
  import cte_pkg::*;

  s1_t        s1_r;
  s1_t        s1_nxt;
  logic [8:0] qcy;
  logic [8:0] qcs;
  logic [8:0] qfy;

  // Century counts for the request year and the start year.
  always_comb begin
    qcy = div100(15'(in_year) + 15'd99);
    qcs = div100(15'(start_year) + 15'd99);
    qfy = div100(15'(in_year));
    s1_nxt.valid      = start;
    s1_nxt.early      = in_year < start_year;
    s1_nxt.year       = in_year;
    s1_nxt.start_year = start_year;
    s1_nxt.q_ceil_y   = qcy[7:0];
    s1_nxt.q_ceil_s   = qcs[7:0];
    s1_nxt.q_floor_y  = qfy[7:0];
    s1_nxt.month      = in_month;
    s1_nxt.day        = in_day;
    s1_nxt.hour       = in_hour;
    s1_nxt.minute     = in_minute;
    s1_nxt.second     = in_second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// File: design/cte_day_count.sv
module cte_day_count (
  input  logic         clk,
  input  logic         rst_n,
  input  cte_pkg::s1_t s1,
  output cte_pkg::s3_t s3
);
  import cte_pkg::*;

  s2_t         s2_r;
  s2_t         s2_nxt;
  s3_t         s3_r;
  s3_t         s3_nxt;
  logic [12:0] leaps_y;
  logic [12:0] leaps_s;
  logic [14:0] century_y;
  logic        is_century;
  logic        is_leap;
  logic [22:0] year_days;

  // Leap years below n are ceil(n/4) - ceil(n/100) + ceil(n/400).
  always_comb begin
    leaps_y = 13'((15'(s1.year) + 15'd3) >> 2) - 13'(s1.q_ceil_y)
            + 13'((9'(s1.q_ceil_y) + 9'd3) >> 2);
    leaps_s = 13'((15'(s1.start_year) + 15'd3) >> 2) - 13'(s1.q_ceil_s)
            + 13'((9'(s1.q_ceil_s) + 9'd3) >> 2);
    century_y  = 15'(s1.q_floor_y) * 15'd100;
    is_century = century_y == 15'(s1.year);
    is_leap    = ((s1.year[1:0] == 2'b00) && !is_century)
              || (is_century && (s1.q_floor_y[1:0] == 2'b00));

    s2_nxt.valid  = s1.valid;
    s2_nxt.early  = s1.early;
    s2_nxt.dyear  = s1.year - s1.start_year;
    s2_nxt.dleap  = 12'(leaps_y - leaps_s);
    s2_nxt.mdays  = DAYS_BEFORE[s1.month]
                  + 9'((s1.month > 4'd2) && is_leap);
    s2_nxt.day    = s1.day;
    s2_nxt.hour   = s1.hour;
    s2_nxt.minute = s1.minute;
    s2_nxt.second = s1.second;
  end

  // Day number since the start, and the seconds within the day.
  always_comb begin
    year_days     = 23'(s2_r.dyear) * 23'd365;
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.early  = s2_r.early;
    s3_nxt.days   = 32'(year_days) + 32'(s2_r.dleap) + 32'(s2_r.mdays)
                  + 32'(s2_r.day) - 32'd1;
    s3_nxt.hms    = 17'(s2_r.hour) * 17'd3600 + 17'(s2_r.minute) * 17'd60
                  + 17'(s2_r.second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

// File: design/cte_scale.sv
`include "calendar_to_epoch_seconds_assert.svh"

module cte_scale (
  input  logic         clk,
  input  logic         rst_n,
  input  cte_pkg::s3_t s3,
  output logic         out_valid,
  output logic [31:0]  out_epoch_seconds
);
  import cte_pkg::*;

  logic        out_valid_r;
  logic [31:0] out_epoch_seconds_r;
  logic [31:0] secs_nxt;

  // The product wraps to 32 bits, matching the modulo behavior of the result.
  always_comb begin
    secs_nxt = s3.early ? 32'd0 : (s3.days * 32'd86400 + 32'(s3.hms));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3.valid;
    end
    out_epoch_seconds_r <= secs_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = out_epoch_seconds_r;

  `CTE_ASSERT_NXT(a_early_zero, clk, rst_n, s3.valid && s3.early, out_epoch_seconds == 32'd0)

endmodule
